@@ hdl/cle_pkg.sv @@
// Shared opcodes, status codes and cell command type for the cursor list engine.
package cle_pkg;

  localparam int OP_W = 4;
  localparam int ST_W = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 4'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 4'd1;
  localparam logic [OP_W-1:0] OP_GET    = 4'd2;
  localparam logic [OP_W-1:0] OP_NEXT   = 4'd3;
  localparam logic [OP_W-1:0] OP_PREV   = 4'd4;
  localparam logic [OP_W-1:0] OP_START  = 4'd5;
  localparam logic [OP_W-1:0] OP_END    = 4'd6;
  localparam logic [OP_W-1:0] OP_SETPOS = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR  = 4'd8;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

@@ hdl/cle_if.sv @@
// Valid/ready channel interfaces for list requests and list results.
interface cle_in_if #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5
);
  logic                      valid;
  logic                      ready;
  logic [cle_pkg::OP_W-1:0]  operation;
  logic [DATA_WIDTH-1:0]     value;
  logic [CNT_W-1:0]          target_position;

  modport source (output valid, output operation, output value, output target_position,
                  input ready);
  modport sink   (input valid, input operation, input value, input target_position,
                  output ready);
endinterface

interface cle_out_if #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5
);
  logic                      valid;
  logic                      ready;
  logic [DATA_WIDTH-1:0]     read_value;
  logic [cle_pkg::ST_W-1:0]  status;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          cursor;

  modport source (output valid, output read_value, output status, output count,
                  output cursor, input ready);
  modport sink   (input valid, input read_value, input status, input count,
                  input cursor, output ready);
endinterface

@@ hdl/cle_cell.sv @@
// One storage cell of the list: holds one element and shifts with its neighbors.
module cle_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                   clk,
  input  cle_pkg::cell_cmd_t     cell_cmd,
  input  logic [CNT_W-1:0]       cursor,
  input  logic [DATA_WIDTH-1:0]  value,
  input  logic [DATA_WIDTH-1:0]  left_q,
  input  logic [DATA_WIDTH-1:0]  right_q,
  output logic [DATA_WIDTH-1:0]  q
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cell_cmd.ins) begin
      // load at the cursor, shift up above it
      if (cursor == IDX_C) begin
        data_nxt = value;
      end else if (cursor < IDX_C) begin
        data_nxt = left_q;
      end
    end else if (cell_cmd.rem) begin
      // close the gap from the cursor upward
      if (cursor <= IDX_C) begin
        data_nxt = right_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

@@ hdl/cle_ctrl.sv @@
// Length and cursor control, request decode and result register.
module cle_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  cle_in_if.sink                 in_bus,
  cle_out_if.source              out_bus,
  input  logic [DATA_WIDTH-1:0]  rd_data,
  output cle_pkg::cell_cmd_t     cell_cmd,
  output logic [CNT_W-1:0]       cursor
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic [CNT_W-1:0]          cursor_r;
  logic [CNT_W-1:0]          cursor_nxt;
  logic                      out_valid_r;
  logic [DATA_WIDTH-1:0]     rd_r;
  logic [cle_pkg::ST_W-1:0]  status_r;
  logic [cle_pkg::ST_W-1:0]  status_nxt;
  logic                      rd_sel;
  logic                      acc;
  cle_pkg::cell_cmd_t        cmd_raw;

  assign in_bus.ready = rst_n && (!out_valid_r || out_bus.ready);
  assign acc          = in_bus.valid && in_bus.ready;

  always_comb begin
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    status_nxt = cle_pkg::ST_OK;
    rd_sel     = 1'b0;
    cmd_raw    = '0;
    unique case (in_bus.operation)
      cle_pkg::OP_INSERT: begin
        if (count_r >= DEPTH_C) begin
          status_nxt = cle_pkg::ST_FULL;
        end else if (cursor_r > count_r) begin
          status_nxt = cle_pkg::ST_RANGE;
        end else begin
          cmd_raw.ins = 1'b1;
          count_nxt   = count_r + 1'b1;
        end
      end
      cle_pkg::OP_REMOVE: begin
        if (count_r == '0) begin
          status_nxt = cle_pkg::ST_EMPTY;
        end else if (cursor_r >= count_r) begin
          status_nxt = cle_pkg::ST_RANGE;
        end else begin
          rd_sel      = 1'b1;
          cmd_raw.rem = 1'b1;
          count_nxt   = count_r - 1'b1;
          // step back when the cursor falls off the end
          if (cursor_r == count_nxt) begin
            cursor_nxt = (count_nxt != '0) ? count_nxt - 1'b1 : '0;
          end
        end
      end
      cle_pkg::OP_GET: begin
        if (count_r == '0) begin
          status_nxt = cle_pkg::ST_EMPTY;
        end else if (cursor_r >= count_r) begin
          status_nxt = cle_pkg::ST_RANGE;
        end else begin
          rd_sel = 1'b1;
        end
      end
      cle_pkg::OP_NEXT: begin
        if (cursor_r >= count_r) begin
          status_nxt = cle_pkg::ST_RANGE;
        end else begin
          cursor_nxt = cursor_r + 1'b1;
        end
      end
      cle_pkg::OP_PREV: begin
        if (cursor_r == '0 || cursor_r >= count_r) begin
          status_nxt = cle_pkg::ST_RANGE;
        end else begin
          cursor_nxt = cursor_r - 1'b1;
        end
      end
      cle_pkg::OP_START: begin
        cursor_nxt = '0;
      end
      cle_pkg::OP_END: begin
        if (count_r == '0) begin
          status_nxt = cle_pkg::ST_EMPTY;
        end else begin
          cursor_nxt = count_r - 1'b1;
        end
      end
      cle_pkg::OP_SETPOS: begin
        if (in_bus.target_position > count_r) begin
          status_nxt = cle_pkg::ST_RANGE;
        end else begin
          cursor_nxt = in_bus.target_position;
        end
      end
      cle_pkg::OP_CLEAR: begin
        count_nxt  = '0;
        cursor_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign cell_cmd = acc ? cmd_raw : '0;
  assign cursor   = cursor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r     <= count_nxt;
        cursor_r    <= cursor_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r     <= rd_sel ? rd_data : '0;
      status_r <= status_nxt;
    end
  end

  // count and cursor only change on a transfer, so they match the held result
  assign out_bus.valid      = out_valid_r;
  assign out_bus.read_value = rd_r;
  assign out_bus.status     = status_r;
  assign out_bus.count      = count_r;
  assign out_bus.cursor     = cursor_r;

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r)
    else $error("cursor beyond list length");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("list length above depth");

  a_fail_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && status_nxt != cle_pkg::ST_OK) |=> ($stable(count_r) && $stable(cursor_r)))
    else $error("failed request changed list state");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_bus.operation != cle_pkg::OP_CLEAR) |=>
      (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
       count_r + 1'b1 == $past(count_r)))
    else $error("list length moved by more than one");

  a_shift_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cell_cmd.ins && cell_cmd.rem))
    else $error("insert and remove shift at once");

endmodule

@@ hdl/cursor_list_engine_core.sv @@
// Positional list with cursor: a row of shifting cells under one controller.
// The result is registered and goes valid in the cycle after the request transfer.
// Throughput: one request per cycle; every cell shifts in parallel, so insert and remove
// finish in the cycle of the transfer; a result that is held waiting stalls the next request.
// Reset (synchronous, rst_n low): length and cursor go to zero, no result pending;
// element cells are not cleared, since only entries below the length are ever read.
module cursor_list_engine_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  cle_in_if.sink     in_bus,
  cle_out_if.source  out_bus
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  cle_pkg::cell_cmd_t     cell_cmd;
  logic [CNT_W-1:0]       cursor;
  logic [DATA_WIDTH-1:0]  cell_q [DEPTH];
  logic [DATA_WIDTH-1:0]  rd_data;

  cle_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .rd_data  (rd_data),
    .cell_cmd (cell_cmd),
    .cursor   (cursor)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_q;
    logic [DATA_WIDTH-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = in_bus.value;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_q = cell_q[i];
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end

    cle_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk      (clk),
      .cell_cmd (cell_cmd),
      .cursor   (cursor),
      .value    (in_bus.value),
      .left_q   (left_q),
      .right_q  (right_q),
      .q        (cell_q[i])
    );
  end

  // only read when the cursor is below the length, so the low bits index a live cell
  assign rd_data = cell_q[cursor[IDX_W-1:0]];

endmodule
